### rtl/core/sorted_table_insert_pop_max_assert.svh
// Assertion macros for the sorted table
`ifndef SORTED_TABLE_INSERT_POP_MAX_ASSERT_SVH
`define SORTED_TABLE_INSERT_POP_MAX_ASSERT_SVH

// same-cycle implication
`define STIPM_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define STIPM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/core/stipm_pkg.sv
package stipm_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int KEY_BITS     = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

    typedef logic [KEY_BITS-1:0]     t_key;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;
    typedef logic [CNT_W-1:0]        t_count;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic ins;
        logic rem;
        logic occ;
        logic tail;
    } t_cell_ctl;

endpackage

### rtl/core/sorted_table_insert_pop_max.sv
// Sorted table with insert and pop-max, held as a chain of cells in descending key order.
// The result item is registered in the cycle after the input item is accepted.
// Throughput: one item per cycle while results are taken; every cell compares and shifts in the same cycle.
// Reset: synchronous active-low i_rst_n clears the entry count and the output valid.
// Cell contents are not cleared by reset; cells at or beyond the count never reach the output.
module sorted_table_insert_pop_max (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [63:0] i_key,
    input  logic [31:0] i_payload,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_out_key,
    output logic [31:0] o_out_payload,
    output logic [4:0]  o_fill
);

    `include "sorted_table_insert_pop_max_assert.svh"

    localparam int DEPTH = stipm_pkg::TABLE_DEPTH;

    stipm_pkg::t_count   r_count, n_count;
    logic                r_out_valid;
    stipm_pkg::t_status  r_status, n_status;
    stipm_pkg::t_key     r_out_key, n_out_key;
    stipm_pkg::t_payload r_out_pay, n_out_pay;

    logic                accept, is_ins, is_rem, full, empty;
    stipm_pkg::t_key     new_key;
    stipm_pkg::t_payload new_pay;

    logic                w_mv       [DEPTH];
    stipm_pkg::t_key     w_key      [DEPTH];
    stipm_pkg::t_payload w_pay      [DEPTH];
    logic                w_left_mv  [DEPTH];
    stipm_pkg::t_key     w_left_key [DEPTH];
    stipm_pkg::t_payload w_left_pay [DEPTH];
    stipm_pkg::t_key     w_right_key[DEPTH];
    stipm_pkg::t_payload w_right_pay[DEPTH];
    stipm_pkg::t_cell_ctl w_ctl     [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == stipm_pkg::CNT_W'(DEPTH));
    assign empty      = (r_count == '0);
    assign is_ins     = accept && (i_action == stipm_pkg::ACT_INSERT) && !full;
    assign is_rem     = accept && (i_action == stipm_pkg::ACT_REMOVE) && !empty;
    assign new_key    = i_key[stipm_pkg::KEY_BITS-1:0];
    assign new_pay    = i_payload[stipm_pkg::PAYLOAD_BITS-1:0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left_mv[g]  = 1'b0;
            assign w_left_key[g] = '0;
            assign w_left_pay[g] = '0;
        end else begin : g_mid
            assign w_left_mv[g]  = w_mv[g-1];
            assign w_left_key[g] = w_key[g-1];
            assign w_left_pay[g] = w_pay[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right_key[g] = '0;
            assign w_right_pay[g] = '0;
        end else begin : g_body
            assign w_right_key[g] = w_key[g+1];
            assign w_right_pay[g] = w_pay[g+1];
        end

        assign w_ctl[g].ins  = is_ins;
        assign w_ctl[g].rem  = is_rem;
        assign w_ctl[g].occ  = stipm_pkg::CNT_W'(g) < r_count;
        assign w_ctl[g].tail = stipm_pkg::CNT_W'(g) == r_count;

        stipm_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[g]),
            .i_new_key  (new_key),
            .i_new_pay  (new_pay),
            .i_left_mv  (w_left_mv[g]),
            .i_left_key (w_left_key[g]),
            .i_left_pay (w_left_pay[g]),
            .i_right_key(w_right_key[g]),
            .i_right_pay(w_right_pay[g]),
            .o_mv       (w_mv[g]),
            .o_key      (w_key[g]),
            .o_pay      (w_pay[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_status  = stipm_pkg::ST_DONE;
        n_out_key = '0;
        n_out_pay = '0;
        unique case (i_action)
            stipm_pkg::ACT_INSERT: begin
                if (full) begin
                    n_status = stipm_pkg::ST_FULL;
                end else begin
                    n_count = r_count + stipm_pkg::CNT_W'(1);
                end
            end
            stipm_pkg::ACT_REMOVE: begin
                if (empty) begin
                    n_status = stipm_pkg::ST_EMPTY;
                end else begin
                    n_count   = r_count - stipm_pkg::CNT_W'(1);
                    n_out_key = w_key[0];
                    n_out_pay = w_pay[0];
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_status  <= n_status;
            r_out_key <= n_out_key;
            r_out_pay <= n_out_pay;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_key     = 64'(r_out_key);
    assign o_out_payload = 32'(r_out_pay);
    assign o_fill        = 5'(r_count);

    `STIPM_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= stipm_pkg::CNT_W'(DEPTH))
    `STIPM_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n,
        accept && i_action == stipm_pkg::ACT_INSERT && full,
        o_status == stipm_pkg::ST_FULL && r_count == $past(r_count))
    `STIPM_ASSERT_NEXT(a_empty_rem, i_clk, i_rst_n,
        accept && i_action == stipm_pkg::ACT_REMOVE && empty,
        o_status == stipm_pkg::ST_EMPTY && o_out_key == '0 && r_count == '0)
    `STIPM_ASSERT_NEXT(a_ins_grow, i_clk, i_rst_n, is_ins,
        r_count == $past(r_count) + stipm_pkg::CNT_W'(1) && o_out_valid)

endmodule

### rtl/core/stipm_cell.sv
module stipm_cell (
    input  logic                  i_clk,
    input  stipm_pkg::t_cell_ctl  i_ctl,
    input  stipm_pkg::t_key       i_new_key,
    input  stipm_pkg::t_payload   i_new_pay,
    input  logic                  i_left_mv,
    input  stipm_pkg::t_key       i_left_key,
    input  stipm_pkg::t_payload   i_left_pay,
    input  stipm_pkg::t_key       i_right_key,
    input  stipm_pkg::t_payload   i_right_pay,
    output logic                  o_mv,
    output stipm_pkg::t_key       o_key,
    output stipm_pkg::t_payload   o_pay
);

    stipm_pkg::t_key     r_key, n_key;
    stipm_pkg::t_payload r_pay, n_pay;

    assign o_mv  = i_ctl.occ && (r_key <= i_new_key);
    assign o_key = r_key;
    assign o_pay = r_pay;

    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        priority if (i_ctl.rem) begin
            n_key = i_right_key;
            n_pay = i_right_pay;
        end else if (i_ctl.ins) begin
            priority if (i_left_mv) begin
                n_key = i_left_key;
                n_pay = i_left_pay;
            end else if (o_mv || i_ctl.tail) begin
                n_key = i_new_key;
                n_pay = i_new_pay;
            end else begin
                n_key = r_key;
                n_pay = r_pay;
            end
        end else begin
            n_key = r_key;
            n_pay = r_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        logic                action;
        stipm_pkg::t_key     key;
        stipm_pkg::t_payload payload;
    } t_op_item;

    typedef struct {
        stipm_pkg::t_status  status;
        stipm_pkg::t_key     key;
        stipm_pkg::t_payload payload;
        stipm_pkg::t_count   fill;
    } t_result_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_action = stipm_pkg::ACT_INSERT;
    logic [63:0] i_key = '0;
    logic [31:0] i_payload = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_out_key;
    logic [31:0] o_out_payload;
    logic [4:0]  o_fill;

    t_op_item     pending_q[$];
    t_result_item result_q[$];

    stipm_pkg::t_key     shadow_key[stipm_pkg::TABLE_DEPTH];
    stipm_pkg::t_payload shadow_payload[stipm_pkg::TABLE_DEPTH];
    int                  shadow_count = 0;

    int total_items = 0;
    int in_count = 0;
    int err_count = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    int hold_stage = 0;

    sorted_table_insert_pop_max dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_fill        (o_fill)
    );

    always #2 i_clk = ~i_clk;

    function automatic int idle_pct(input bit sender);
        int phase;
        phase = (total_items == 0) ? 0 : (in_count * 3) / total_items;
        if (phase == 0) begin
            return sender ? 28 : 76;
        end else if (phase == 1) begin
            return sender ? 76 : 28;
        end
        return 0;
    endfunction

    function automatic stipm_pkg::t_key pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            return stipm_pkg::t_key'($urandom_range(7));
        end else if (sel < 80) begin
            return {$urandom, $urandom};
        end else begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return {1'b1, 63'd0};
                default: return {63'h7FFF_FFFF_FFFF_FFFF, 1'b0};
            endcase
        end
    endfunction

    task automatic push_item(input logic act, input stipm_pkg::t_key k,
                             input stipm_pkg::t_payload p);
        t_op_item it;
        it.action = act;
        it.key = k;
        it.payload = p;
        pending_q.push_back(it);
    endtask

    task automatic table_apply(input logic act, input stipm_pkg::t_key k,
                               input stipm_pkg::t_payload p,
                               output t_result_item r);
        int pos;
        r.key = '0;
        r.payload = '0;
        if (act == stipm_pkg::ACT_INSERT) begin
            if (shadow_count >= stipm_pkg::TABLE_DEPTH) begin
                r.status = stipm_pkg::ST_FULL;
            end else begin
                pos = shadow_count;
                while (pos > 0 && shadow_key[pos-1] > k) begin
                    shadow_key[pos] = shadow_key[pos-1];
                    shadow_payload[pos] = shadow_payload[pos-1];
                    pos--;
                end
                shadow_key[pos] = k;
                shadow_payload[pos] = p;
                shadow_count++;
                r.status = stipm_pkg::ST_DONE;
            end
        end else if (shadow_count == 0) begin
            r.status = stipm_pkg::ST_EMPTY;
        end else begin
            shadow_count--;
            r.key = shadow_key[shadow_count];
            r.payload = shadow_payload[shadow_count];
            r.status = stipm_pkg::ST_DONE;
        end
        r.fill = stipm_pkg::t_count'(shadow_count);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : driver
        t_op_item     cur;
        t_result_item res;
        logic         next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                table_apply(i_action, i_key, i_payload, res);
                result_q.push_back(res);
                in_count++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_q.size() > 0 &&
                $urandom_range(99) >= idle_pct(1'b1)) begin
                cur = pending_q.pop_front();
                i_action <= cur.action;
                i_key <= cur.key;
                i_payload <= cur.payload;
                next_valid = 1'b1;
            end
            i_in_valid <= next_valid;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (i_rst_n && hold_stage < 2 &&
                     in_count >= ((hold_stage == 0) ? total_items / 2
                                                    : (total_items * 5) / 6)) begin
            hold_left <= HOLD_CYCLES;
            hold_stage <= hold_stage + 1;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
    end

    always @(posedge i_clk) begin : monitor
        t_result_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result, status", 64'(o_status), '0);
            end else begin
                want = result_q.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                end
                if (o_out_key !== want.key) begin
                    report_mismatch("out_key", o_out_key, want.key);
                end
                if (o_out_payload !== want.payload) begin
                    report_mismatch("out_payload", 64'(o_out_payload), 64'(want.payload));
                end
                if (o_fill !== want.fill) begin
                    report_mismatch("fill", 64'(o_fill), 64'(want.fill));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("sorted_table_insert_pop_max regression: fail");
            $finish;
        end
    end

    initial begin
        stipm_pkg::t_key dir_keys[16];
        int              made;
        int              burst;
        int              ins_pct;
        dir_keys = '{64'd0, '1, 64'd5, 64'd5, 64'd5, {1'b1, 63'd0}, '1, 64'd1,
                     64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd5, 64'd0,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'd2, 64'hAAAA_AAAA_5555_5555, 64'd3};

        // remove from empty, fill to capacity with ties and extremes, overflow, drain part
        push_item(stipm_pkg::ACT_REMOVE, '1, '1);
        for (int i = 0; i < 16; i++) begin
            push_item(stipm_pkg::ACT_INSERT, dir_keys[i],
                      (i == 1) ? 32'hFFFF_FFFF : stipm_pkg::t_payload'(i));
        end
        push_item(stipm_pkg::ACT_INSERT, 64'd4, 32'hDEAD_BEEF);
        for (int i = 0; i < 7; i++) begin
            push_item(stipm_pkg::ACT_REMOVE, {$urandom, $urandom}, $urandom);
        end

        made = 0;
        while (made < RANDOM_ITEMS) begin
            burst = $urandom_range(10, 60);
            case ($urandom_range(4))
                0: ins_pct = 80;
                1: ins_pct = 20;
                2: ins_pct = 50;
                3: ins_pct = 95;
                default: ins_pct = 5;
            endcase
            for (int j = 0; j < burst && made < RANDOM_ITEMS; j++) begin
                if ($urandom_range(99) < ins_pct) begin
                    push_item(stipm_pkg::ACT_INSERT, pick_key(), $urandom);
                end else begin
                    push_item(stipm_pkg::ACT_REMOVE, {$urandom, $urandom}, $urandom);
                end
                made++;
            end
        end
        total_items = pending_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_in_valid || result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (err_count == 0) begin
            $display("sorted_table_insert_pop_max regression: pass");
        end else begin
            $display("sorted_table_insert_pop_max regression: fail");
        end
        $finish;
    end

endmodule
